// ----- rtl/fifo_mutex_with_waiter_queue_unit_assert.svh -----
// Assertion macros used by the waiter queue of the queued lock RTL.
// Depends on nothing; assertions vanish when SYNTHESIS is defined.
`ifndef FIFO_MUTEX_WITH_WAITER_QUEUE_UNIT_ASSERT_SVH
`define FIFO_MUTEX_WITH_WAITER_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define FMWQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define FMWQ_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define FMWQ_ASSERT(label, clk, rst_n, prop, msg)
`define FMWQ_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ----- rtl/fmwq_pkg.sv -----
// Types and constants for the FIFO queued mutex.
// Used by every module of the block; depends on nothing.
package fmwq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		OP_ACQUIRE = 3'd0,
		OP_RELEASE = 3'd1,
		OP_QUERY   = 3'd2,
		OP_RSET    = 3'd3,
		OP_RUNSET  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_WAIT = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] txn_id;
		logic [31:0] batch_id;
		logic [7:0]  thread_id;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        section_free;
		logic        restart_valid;
		logic [31:0] restart_txn_id;
		logic [31:0] restart_batch_id;
		logic [7:0]  restart_thread_id;
	} rsp_t;

	// Commands from the lock logic to the waiter queue.
	typedef struct packed {
		logic        push;
		logic        pop;
		logic [31:0] txn;
		logic [31:0] batch;
	} qctl_t;

	// Status of the waiter queue seen by the lock logic.
	typedef struct packed {
		logic        empty;
		logic        full;
		logic [31:0] head_txn;
		logic [31:0] head_batch;
	} qstat_t;

endpackage

// ----- rtl/fmwq_waitq.sv -----
// Circular FIFO of waiting transactions and their batch ids.
// Depends on fmwq_pkg and the assertion macro header.
`include "fifo_mutex_with_waiter_queue_unit_assert.svh"

module fmwq_waitq
	import fmwq_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  qctl_t  ctl,
	output qstat_t stat
);

	logic [31:0]       txn_mem [QUEUE_DEPTH];
	logic [31:0]       batch_mem [QUEUE_DEPTH];
	logic [31:0]       head_txn_q;
	logic [31:0]       head_batch_q;
	logic [QPTR_W-1:0] head_q;
	logic [QPTR_W-1:0] tail_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] next_slot(input logic [QPTR_W-1:0] i);
		logic [QPTR_W-1:0] r;
		if (i == QPTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = i + QPTR_W'(1);
		end
		return r;
	endfunction

	// The head entry is kept in a register: it is loaded by a push into an empty
	// queue, and on a pop it takes the entry behind the one that leaves.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			txn_mem[tail_q]   <= ctl.txn;
			batch_mem[tail_q] <= ctl.batch;
		end
		if (ctl.push && (count_q == '0)) begin
			head_txn_q   <= ctl.txn;
			head_batch_q <= ctl.batch;
		end else if (ctl.pop) begin
			head_txn_q   <= txn_mem[next_slot(head_q)];
			head_batch_q <= batch_mem[next_slot(head_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.push) begin
				tail_q  <= next_slot(tail_q);
				count_q <= count_q + QCNT_W'(1);
			end else if (ctl.pop) begin
				head_q  <= next_slot(head_q);
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	assign stat.empty      = (count_q == '0);
	assign stat.full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.head_txn   = head_txn_q;
	assign stat.head_batch = head_batch_q;

	`FMWQ_NEVER(a_push_full, clk, arst_n, ctl.push && stat.full, "push into a full waiter queue")
	`FMWQ_NEVER(a_pop_empty, clk, arst_n, ctl.pop && stat.empty, "pop from an empty waiter queue")
	`FMWQ_NEVER(a_push_pop, clk, arst_n, ctl.push && ctl.pop, "push and pop for the same item")
	`FMWQ_ASSERT(a_cnt_ptr, clk, arst_n, ctl.push |=> (tail_q != $past(tail_q)) && (count_q == $past(count_q) + QCNT_W'(1)), "tail or count did not advance on push")

endmodule

// ----- rtl/fmwq_lock.sv -----
// Owner register and per-item decision logic of the queued mutex.
// Depends on fmwq_pkg; drives the waiter queue through qctl_t.
module fmwq_lock
	import fmwq_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  req_t   req,
	input  qstat_t qstat,
	output qctl_t  qctl,
	output rsp_t   rsp
);

	logic        held_q;
	logic [31:0] owner_q;
	logic        held_d;
	logic [31:0] owner_d;
	logic        push;
	logic        pop;
	logic        is_owner;

	assign is_owner = held_q && (owner_q == req.txn_id);

	always_comb begin
		held_d = held_q;
		owner_d = owner_q;
		push = 1'b0;
		pop = 1'b0;
		rsp = '0;
		rsp.status = ST_OK;
		rsp.section_free = !held_q;
		case (op_t'(req.operation))
			OP_ACQUIRE: begin
				if (!held_q) begin
					held_d = 1'b1;
					owner_d = req.txn_id;
				end else if (!is_owner) begin
					if (qstat.full) begin
						rsp.status = ST_FULL;
					end else begin
						push = 1'b1;
						rsp.status = ST_WAIT;
					end
				end
			end
			OP_RELEASE: begin
				if (is_owner) begin
					if (qstat.empty) begin
						held_d = 1'b0;
						owner_d = '0;
					end else begin
						// Hand the lock straight to the oldest waiter.
						pop = 1'b1;
						owner_d = qstat.head_txn;
						rsp.restart_valid = 1'b1;
						rsp.restart_txn_id = qstat.head_txn;
						rsp.restart_batch_id = qstat.head_batch;
						rsp.restart_thread_id = req.thread_id;
					end
				end
			end
			OP_RSET: begin
				if (!held_q) begin
					held_d = 1'b1;
					owner_d = req.txn_id;
				end
			end
			OP_RUNSET: begin
				held_d = 1'b0;
				owner_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign qctl.push  = en && push;
	assign qctl.pop   = en && pop;
	assign qctl.txn   = req.txn_id;
	assign qctl.batch = req.batch_id;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 1'b0;
			owner_q <= '0;
		end else if (en) begin
			held_q  <= held_d;
			owner_q <= owner_d;
		end
	end

endmodule

// ----- rtl/fifo_mutex_with_waiter_queue_unit.sv -----
// Top level of the FIFO queued mutex: input register, lock logic, result register.
// Depends on fmwq_pkg, fmwq_lock and fmwq_waitq.
//
// Each request is taken into an input register, decided against the owner register and
// the 16-entry waiter queue, and its single result is held in an output register. The
// block sustains one request per clock while results are picked up; a result is offered
// once its request has passed through both registers. The owner register is written once
// per request, a queue pointer at most once. A new request is taken while a result
// still waits to be picked up. No clearing pass follows reset; the block is ready at once.
module fifo_mutex_with_waiter_queue_unit
	import fmwq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	req_t   req_s1;
	logic   req_valid_s1;
	logic   advance;
	rsp_t   rsp_d;
	rsp_t   rsp_q;
	logic   rsp_valid_q;
	qctl_t  qctl;
	qstat_t qstat;

	// The item in the input register moves on once the result register is free.
	assign advance   = req_valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !req_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req_ready) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	fmwq_lock u_lock (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.req    (req_s1),
		.qstat  (qstat),
		.qctl   (qctl),
		.rsp    (rsp_d)
	);

	fmwq_waitq u_waitq (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (qctl),
		.stat   (qstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
